/* rtl/core/bitmap_contiguous_block_allocator_assert.svh */
// Assertion macros for the block allocator.
`ifndef BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bcba_pkg.sv */
package bcba_pkg;

    localparam int POS_W   = 13;  // block position, up to the largest limit
    localparam int WORD_W  = 8;   // bitmap word index within the position space
    localparam int BITS_W  = 32;  // blocks per bitmap word
    localparam int BLK_W   = 12;
    localparam int CNT_W   = 13;

    localparam logic [BITS_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

    localparam logic CFG_IDX_AREA_BASE = 1'b0;
    localparam logic CFG_IDX_BLK_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_MARK  = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_TEST  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type          req_type;
        logic [BLK_W-1:0]   block;
        logic [CNT_W-1:0]   count;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [BLK_W-1:0]   first_blk;
        logic               is_used;
    } t_res;

    typedef struct packed {
        logic               init;
        logic               step;
        logic [WORD_W-1:0]  word;
        logic [BITS_W-1:0]  free_bits;
    } t_scan_ctl;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   start;
    } t_scan_res;

endpackage

/* rtl/core/bitmap_contiguous_block_allocator.sv */
// Bitmap first-fit block allocator: one used/free bit per block, kept in a
// RAM of 32-bit words.
// Request channel: i_req is taken at a clock edge with start high and busy
// low. Every transaction gives exactly one result: o_res is valid for one cycle
// while o_res_valid is high; the receiver cannot stall and must take it then.
// Flow, one RAM word read per cycle:
//   count of zero, or a range/limit error: answered in the next cycle, and
//     busy stays low, so a new request may follow at once.
//   test: reads the block's word, then answers.  mark/free: reads each word
//     of the range and writes it back updated.
//   allocate: scans words from the first data block until a run fits, then
//     marks it; with no fit, answers no-space after the last word.
// Rate is set by the single read port of the bitmap RAM; marking overlaps
// the read of the next word with the write of the current one.
// Reset: after i_rst_n the bitmap is cleared one word per cycle,
//   with busy high; APB writes are taken meanwhile.
// Configuration: APB registers first data block (0x0) and block count (0x4);
// the user writes them only while no request is outstanding; not enforced.
module bitmap_contiguous_block_allocator #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bcba_pkg::t_req        i_req,
    output logic                  o_res_valid,
    output bcba_pkg::t_res        o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    import bcba_pkg::*;

    localparam int DEPTH = (NUM_BLOCKS + BITS_W - 1) / BITS_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LIM_CAP = (NUM_BLOCKS < 8191) ? NUM_BLOCKS : 8191;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TEST,
        S_SCAN,
        S_FILL
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [BLK_W-1:0]   r_blk, n_blk;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [POS_W-1:0]   r_lo, n_lo;
    logic [POS_W-1:0]   r_last, n_last;
    logic [WORD_W-1:0]  r_rd_word, n_rd_word;
    logic [WORD_W-1:0]  r_last_word, n_last_word;
    logic               r_rd_more, n_rd_more;
    logic               r_pend_vld, n_pend_vld;
    logic [WORD_W-1:0]  r_pend_word, n_pend_word;
    logic               r_set, n_set;
    logic               r_out_vld, n_out_vld;
    t_res               r_out, n_out;

    logic [BLK_W-1:0]   r_area_base;
    logic [CNT_W-1:0]   r_total;
    logic [POS_W-1:0]   lim;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BITS_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [BITS_W-1:0]  ram_rdata;

    t_scan_ctl          scan_ctl;
    t_scan_res          scan_res;

    logic               accept;
    logic               cfg_wr;
    logic [POS_W:0]     range_end;
    logic [POS_W-1:0]   alloc_last;
    logic [BITS_W-1:0]  wmask;

    function automatic logic [BITS_W-1:0] range_mask(
        input logic [WORD_W-1:0] w,
        input logic [POS_W-1:0]  lo,
        input logic [POS_W-1:0]  last
    );
        logic [4:0] sb;
        logic [4:0] eb;
        sb = (w == lo[POS_W-1:5]) ? lo[4:0] : 5'd0;
        eb = (w == last[POS_W-1:5]) ? last[4:0] : 5'd31;
        range_mask = (WORD_ONES << sb) & (WORD_ONES >> (5'd31 - eb));
    endfunction

    bcba_ram #(
        .WIDTH (BITS_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bcba_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_cnt   (r_cnt),
        .o_res   (scan_res)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_base <= '0;
            r_total     <= CNT_W'(4096);
        end else if (cfg_wr) begin
            case (paddr[2])
                CFG_IDX_AREA_BASE: r_area_base <= pwdata[BLK_W-1:0];
                CFG_IDX_BLK_LIMIT: r_total     <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_IDX_AREA_BASE: prdata = 32'(r_area_base);
            CFG_IDX_BLK_LIMIT: prdata = 32'(r_total);
            default:           prdata = '0;
        endcase
    end

    assign lim    = (r_total > POS_W'(LIM_CAP)) ? POS_W'(LIM_CAP) : r_total;
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_blk       = r_blk;
        n_cnt       = r_cnt;
        n_lo        = r_lo;
        n_last      = r_last;
        n_rd_word   = r_rd_word;
        n_last_word = r_last_word;
        n_rd_more   = r_rd_more;
        n_pend_vld  = 1'b0;
        n_pend_word = r_pend_word;
        n_set       = r_set;
        n_out_vld   = 1'b0;
        n_out       = r_out;

        ram_we    = 1'b0;
        ram_waddr = AW'(r_pend_word);
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = AW'(r_rd_word);

        range_end  = {2'b00, i_req.block} + {1'b0, i_req.count};
        alloc_last = scan_res.start + r_cnt - POS_W'(1);
        wmask      = range_mask(r_pend_word, r_lo, r_last);

        scan_ctl.init      = 1'b0;
        scan_ctl.step      = 1'b0;
        scan_ctl.word      = r_pend_word;
        scan_ctl.free_bits = ~ram_rdata & wmask;

        // shared word reader for test, scan and fill
        if (r_state == S_TEST || r_state == S_SCAN || r_state == S_FILL) begin
            if (r_rd_more) begin
                ram_re      = 1'b1;
                n_pend_vld  = 1'b1;
                n_pend_word = r_rd_word;
                n_rd_word   = r_rd_word + WORD_W'(1);
                if (r_rd_word == r_last_word) begin
                    n_rd_more = 1'b0;
                end
            end
        end

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_blk      = i_req.block;
                    n_cnt      = i_req.count;
                    n_out      = '{status: ST_OK, first_blk: '0, is_used: 1'b0};
                    case (i_req.req_type)
                        REQ_ALLOC: begin
                            if (i_req.count == '0) begin
                                n_out.first_blk = r_area_base;
                                n_out_vld       = 1'b1;
                            end else if ({1'b0, r_area_base} >= lim) begin
                                n_out.status = ST_NOSPACE;
                                n_out_vld    = 1'b1;
                            end else begin
                                n_lo          = {1'b0, r_area_base};
                                n_last        = lim - POS_W'(1);
                                n_rd_word     = WORD_W'(r_area_base[BLK_W-1:5]);
                                n_last_word   = n_last[POS_W-1:5];
                                n_rd_more     = 1'b1;
                                scan_ctl.init = 1'b1;
                                n_state       = S_SCAN;
                            end
                        end
                        REQ_MARK, REQ_FREE: begin
                            if (i_req.count == '0) begin
                                n_out_vld = 1'b1;
                            end else if (range_end > {1'b0, lim}) begin
                                n_out.status = ST_RANGE;
                                n_out_vld    = 1'b1;
                            end else begin
                                n_lo        = {1'b0, i_req.block};
                                n_last      = range_end[POS_W-1:0] - POS_W'(1);
                                n_rd_word   = WORD_W'(i_req.block[BLK_W-1:5]);
                                n_last_word = n_last[POS_W-1:5];
                                n_rd_more   = 1'b1;
                                n_set       = (i_req.req_type == REQ_MARK);
                                n_state     = S_FILL;
                            end
                        end
                        REQ_TEST: begin
                            if ({1'b0, i_req.block} >= lim) begin
                                // unreachable block reads as used
                                n_out.status  = ST_RANGE;
                                n_out.is_used = 1'b1;
                                n_out_vld     = 1'b1;
                            end else begin
                                n_rd_word   = WORD_W'(i_req.block[BLK_W-1:5]);
                                n_last_word = WORD_W'(i_req.block[BLK_W-1:5]);
                                n_rd_more   = 1'b1;
                                n_state     = S_TEST;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_TEST: begin
                if (r_pend_vld) begin
                    n_out.is_used = ram_rdata[r_blk[4:0]];
                    n_out_vld     = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            S_SCAN: begin
                scan_ctl.step = r_pend_vld;
                if (r_pend_vld) begin
                    if (scan_res.found) begin
                        // drop reads still in flight and mark the run
                        n_out.first_blk = scan_res.start[BLK_W-1:0];
                        n_lo        = scan_res.start;
                        n_last      = alloc_last;
                        n_rd_word   = scan_res.start[POS_W-1:5];
                        n_last_word = alloc_last[POS_W-1:5];
                        n_rd_more   = 1'b1;
                        n_pend_vld  = 1'b0;
                        n_set       = 1'b1;
                        n_state     = S_FILL;
                    end else if (r_pend_word == r_last_word) begin
                        n_out.status = ST_NOSPACE;
                        n_out_vld    = 1'b1;
                        n_rd_more    = 1'b0;
                        n_pend_vld   = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_FILL: begin
                if (r_pend_vld) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_set ? (ram_rdata | wmask) : (ram_rdata & ~wmask);
                    if (r_pend_word == r_last_word) begin
                        n_out_vld = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_rd_more  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_blk       <= n_blk;
            r_cnt       <= n_cnt;
            r_lo        <= n_lo;
            r_last      <= n_last;
            r_rd_word   <= n_rd_word;
            r_last_word <= n_last_word;
            r_rd_more   <= n_rd_more;
            r_pend_vld  <= n_pend_vld;
            r_pend_word <= n_pend_word;
            r_set       <= n_set;
            r_out_vld   <= n_out_vld;
            r_out       <= n_out;
        end
    end

`include "bitmap_contiguous_block_allocator_assert.svh"

    `BCBA_ASSERT_NOW(a_no_rw_collide, i_clk, i_rst_n, ram_we && ram_re,
        ram_waddr != ram_raddr, "bitmap read and write hit the same word")
    `BCBA_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy,
        busy || o_res_valid, "accepted transaction neither busy nor answered")
    `BCBA_ASSERT_NOW(a_nospace_clean, i_clk, i_rst_n,
        o_res_valid && (o_res.status == ST_NOSPACE),
        (o_res.first_blk == '0) && !o_res.is_used, "no-space result carries data")
    `BCBA_ASSERT_NOW(a_pend_in_range, i_clk, i_rst_n, r_pend_vld,
        r_pend_word <= r_last_word, "pending word beyond the range end")

endmodule

/* rtl/core/bcba_ram.sv */
module bcba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bcba_scan.sv */
module bcba_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bcba_pkg::t_scan_ctl         i_ctl,
    input  logic [bcba_pkg::CNT_W-1:0]  i_cnt,
    output bcba_pkg::t_scan_res         o_res
);

    import bcba_pkg::*;

    logic [POS_W-1:0]  r_carry;
    logic [POS_W-1:0]  r_run_head;
    logic [POS_W-1:0]  n_carry;
    logic [POS_W-1:0]  n_run_head;

    logic [BITS_W-1:0] f;
    logic [BITS_W-1:0] h [6];
    logic [BITS_W-1:0] fit;
    logic [5:0]        off;
    logic [5:0]        tz;
    logic [5:0]        lz;
    logic [4:0]        fit_idx;
    logic [POS_W-1:0]  base;
    logic [POS_W:0]    head_len;
    logic              via_carry;
    logic              short_req;
    logic              fit_any;
    logic              found;

    always_comb begin
        f    = i_ctl.free_bits;
        base = {i_ctl.word, 5'd0};

        // trailing and leading free counts
        tz = 6'd32;
        for (int i = BITS_W - 1; i >= 0; i--) begin
            if (!f[i]) begin
                tz = 6'(i);
            end
        end
        lz = 6'd32;
        for (int i = 0; i < BITS_W; i++) begin
            if (!f[i]) begin
                lz = 6'(BITS_W - 1 - i);
            end
        end

        // h[b][x]: blocks x .. x+2^b-1 all free inside this word
        h[0] = f;
        for (int b = 0; b < 5; b++) begin
            h[b+1] = h[b] & (h[b] >> (1 << b));
        end
        fit = WORD_ONES;
        off = '0;
        for (int b = 0; b < 6; b++) begin
            if (i_cnt[b]) begin
                fit = fit & (h[b] >> off);
                off = off + 6'(1 << b);
            end
        end
        short_req = (i_cnt <= CNT_W'(BITS_W));
        fit_any   = short_req && (|fit);
        fit_idx   = '0;
        for (int i = BITS_W - 1; i >= 0; i--) begin
            if (fit[i]) begin
                fit_idx = 5'(i);
            end
        end

        head_len  = {1'b0, r_carry} + (POS_W+1)'(tz);
        via_carry = (head_len >= {1'b0, i_cnt});
        found     = i_ctl.step && (via_carry || fit_any);

        o_res.found = found;
        if (via_carry) begin
            o_res.start = (r_carry != '0) ? r_run_head : base;
        end else begin
            o_res.start = base + POS_W'(fit_idx);
        end

        n_carry    = r_carry;
        n_run_head = r_run_head;
        if (i_ctl.init) begin
            n_carry = '0;
        end else if (i_ctl.step && !found) begin
            if (&f) begin
                n_carry    = r_carry + POS_W'(BITS_W);
                n_run_head = (r_carry == '0) ? base : r_run_head;
            end else begin
                // a new run may begin after the highest used block
                n_carry    = POS_W'(lz);
                n_run_head = base + POS_W'(BITS_W) - POS_W'(lz);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
        end
        r_run_head <= n_run_head;
    end

endmodule
